/* design/tlsrf_pkg.sv */
// ----------------------------------------------------------------------------
// tlsrf_pkg
// shared constants, types and helpers for the tls record framer and
// handshake timer
// ----------------------------------------------------------------------------
package tlsrf_pkg;

	localparam int TIME_WIDTH = 48;
	localparam int FIELD_TIME_W = 48;
	localparam int STAMP_W = (TIME_WIDTH < FIELD_TIME_W) ? TIME_WIDTH : FIELD_TIME_W;

	localparam int HDR_BYTES = 5;
	localparam int HDR_CNT_W = 3;
	localparam logic [HDR_CNT_W-1:0] HDR_POS_TYPE = HDR_CNT_W'(0);
	localparam logic [HDR_CNT_W-1:0] HDR_POS_LEN_HI = HDR_CNT_W'(3);
	localparam logic [HDR_CNT_W-1:0] HDR_POS_LEN_LO = HDR_CNT_W'(4);
	localparam logic [HDR_CNT_W-1:0] HDR_DONE = HDR_CNT_W'(HDR_BYTES);

	localparam logic [7:0] TYPE_CCS = 8'd20;
	localparam logic [7:0] TYPE_ALERT = 8'd21;
	localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;
	localparam logic [7:0] TYPE_APPDATA = 8'd23;

	localparam logic [2:0] CLASS_CCS = 3'd0;
	localparam logic [2:0] CLASS_ALERT = 3'd1;
	localparam logic [2:0] CLASS_HANDSHAKE = 3'd2;
	localparam logic [2:0] CLASS_APPDATA = 3'd3;
	localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0]         rec_type;
		logic [15:0]        rec_len;
		logic [STAMP_W-1:0] stamp;
	} rec_t;

	typedef struct packed {
		logic        full;
		logic        empty;
	} q_status_t;

	function automatic logic [2:0] class_of(input logic [7:0] t);
		logic [2:0] c;
		unique case (t)
			TYPE_CCS:       c = CLASS_CCS;
			TYPE_ALERT:     c = CLASS_ALERT;
			TYPE_HANDSHAKE: c = CLASS_HANDSHAKE;
			TYPE_APPDATA:   c = CLASS_APPDATA;
			default:        c = CLASS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

/* design/tlsrf_framer.sv */
// ----------------------------------------------------------------------------
// tlsrf_framer
// front end: takes stream bytes, walks the record header and counts off the
// payload, and pushes one record into the queue when a record closes
// ----------------------------------------------------------------------------
module tlsrf_framer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	input  logic [47:0]              in_time,
	input  tlsrf_pkg::q_status_t     q_status,
	output logic                     q_push,
	output tlsrf_pkg::rec_t          q_rec
);

	logic [tlsrf_pkg::HDR_CNT_W-1:0] hdr_cnt_q;
	logic [7:0]                      type_q;
	logic [7:0]                      len_hi_q;
	logic [15:0]                     len_q;
	logic [15:0]                     left_q;
	logic                            active_q;
	logic                            take;
	logic                            in_hdr;
	logic                            hdr_last;
	logic [15:0]                     len_full;
	logic [7:0]                      cur_type;
	logic                            close;

	assign in_ready = !active_q || !q_status.full;
	assign take = in_valid && in_ready && active_q;
	assign in_hdr = hdr_cnt_q != tlsrf_pkg::HDR_DONE;
	assign hdr_last = hdr_cnt_q == tlsrf_pkg::HDR_POS_LEN_LO;
	assign len_full = {len_hi_q, in_byte};
	assign cur_type = type_q;

	always_comb begin
		if (in_hdr) begin
			close = hdr_last && (len_full == 16'd0);
		end else begin
			close = left_q == 16'd1;
		end
	end

	assign q_push = take && close;
	assign q_rec.rec_type = cur_type;
	assign q_rec.rec_len = in_hdr ? len_full : len_q;
	assign q_rec.stamp = in_time[tlsrf_pkg::STAMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			left_q <= '0;
			active_q <= 1'b1;
		end else if (take) begin
			if (close) begin
				hdr_cnt_q <= '0;
				left_q <= '0;
				if (cur_type == tlsrf_pkg::TYPE_APPDATA) begin
					active_q <= 1'b0;
				end
			end else if (in_hdr) begin
				hdr_cnt_q <= hdr_cnt_q + 1'b1;
				if (hdr_last) begin
					left_q <= len_full;
				end
			end else begin
				left_q <= left_q - 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_hdr) begin
			if (hdr_cnt_q == tlsrf_pkg::HDR_POS_TYPE) begin
				type_q <= in_byte;
			end
			if (hdr_cnt_q == tlsrf_pkg::HDR_POS_LEN_HI) begin
				len_hi_q <= in_byte;
			end
			if (hdr_last) begin
				len_q <= len_full;
			end
		end
	end

endmodule

/* design/tlsrf_queue.sv */
// ----------------------------------------------------------------------------
// tlsrf_queue
// short fifo of closed records between the framer and the timer
// ----------------------------------------------------------------------------
module tlsrf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tlsrf_pkg::rec_t      push_rec,
	input  logic                 pop,
	output tlsrf_pkg::rec_t      head_rec,
	output tlsrf_pkg::q_status_t status
);

	tlsrf_pkg::rec_t                  slots_q [tlsrf_pkg::QDEPTH];
	logic [tlsrf_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tlsrf_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tlsrf_pkg::QCNT_W-1:0]     count_q;

	assign status.full = count_q == tlsrf_pkg::QCNT_W'(tlsrf_pkg::QDEPTH);
	assign status.empty = count_q == '0;
	assign head_rec = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

/* design/tlsrf_timer.sv */
// ----------------------------------------------------------------------------
// tlsrf_timer
// back end: applies each closed record to the handshake timing state and
// holds the result in the output register
// ----------------------------------------------------------------------------
module tlsrf_timer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlsrf_pkg::rec_t      head_rec,
	input  tlsrf_pkg::q_status_t q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           record_type,
	output logic [2:0]           record_class,
	output logic [15:0]          payload_len,
	output logic                 start_seen,
	output logic [47:0]          handshake_start_time,
	output logic [47:0]          handshake_end_time,
	output logic                 handshake_done
);

	logic                           start_valid_q;
	logic [tlsrf_pkg::STAMP_W-1:0]  start_q;
	logic [tlsrf_pkg::STAMP_W-1:0]  end_q;
	logic                           done_q;
	logic                           out_valid_q;
	logic [7:0]                     type_q;
	logic [15:0]                    len_q;
	logic                           timed;
	logic                           is_app;
	logic                           nxt_start_valid;
	logic [tlsrf_pkg::STAMP_W-1:0]  nxt_start;
	logic [tlsrf_pkg::STAMP_W-1:0]  nxt_end;
	logic                           nxt_done;

	assign pop = !q_status.empty && (!out_valid_q || out_ready);
	assign timed = ((head_rec.rec_type == tlsrf_pkg::TYPE_CCS) ||
		(head_rec.rec_type == tlsrf_pkg::TYPE_HANDSHAKE)) && !done_q;
	assign is_app = head_rec.rec_type == tlsrf_pkg::TYPE_APPDATA;

	always_comb begin
		nxt_start_valid = start_valid_q;
		nxt_start = start_q;
		nxt_end = end_q;
		nxt_done = done_q;
		if (timed) begin
			if (!start_valid_q) begin
				nxt_start_valid = 1'b1;
				nxt_start = head_rec.stamp;
			end
			nxt_end = head_rec.stamp;
		end else if (is_app) begin
			nxt_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_valid_q <= 1'b0;
			start_q <= '0;
			end_q <= '0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				start_valid_q <= nxt_start_valid;
				start_q <= nxt_start;
				end_q <= nxt_end;
				done_q <= nxt_done;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			type_q <= head_rec.rec_type;
			len_q <= head_rec.rec_len;
		end
	end

	assign out_valid = out_valid_q;
	assign record_type = type_q;
	assign record_class = tlsrf_pkg::class_of(type_q);
	assign payload_len = len_q;
	assign start_seen = start_valid_q;
	assign handshake_start_time = 48'(start_q);
	assign handshake_end_time = 48'(end_q);
	assign handshake_done = done_q;

endmodule

/* design/tls_record_framer_handshake_timer_top.sv */
// ----------------------------------------------------------------------------
// tls_record_framer_handshake_timer_top
// tls record framer with handshake start and end time capture
// ----------------------------------------------------------------------------
// Takes one stream byte per clock with its 48-bit arrival time. Each record's
// 5-byte header and payload are counted off in the framer, and every closed
// record enters a 4-entry queue; the timer then applies it to the handshake
// timing state and presents one result per record on the output stream.
// Throughput is one byte per cycle while the output is drained; a stalled
// output backs up into the queue and the input stalls only when the queue is
// full. After an application-data record the block drops every further byte
// (ready stays high) until reset.
module tls_record_framer_handshake_timer_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// stream_byte[7:0], arrival_time[55:8]
	input  logic [55:0]   s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// record_type[7:0], payload_len[23:8], start_seen[24],
	// handshake_start_time[72:25], handshake_end_time[120:73],
	// handshake_done[121], zero[127:122]
	output logic [127:0]  m_axis_tdata,
	// record_class[2:0]
	output logic [2:0]    m_axis_tuser
);

	tlsrf_pkg::q_status_t q_status;
	tlsrf_pkg::rec_t      push_rec;
	tlsrf_pkg::rec_t      head_rec;
	logic                 q_push;
	logic                 q_pop;
	logic [7:0]           record_type;
	logic [15:0]          payload_len;
	logic                 start_seen;
	logic [47:0]          handshake_start_time;
	logic [47:0]          handshake_end_time;
	logic                 handshake_done;

	tlsrf_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata[7:0]),
		.in_time  (s_axis_tdata[55:8]),
		.q_status (q_status),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	tlsrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.pop      (q_pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	tlsrf_timer u_timer (
		.clk                  (clk),
		.arst_n               (arst_n),
		.head_rec             (head_rec),
		.q_status             (q_status),
		.pop                  (q_pop),
		.out_valid            (m_axis_tvalid),
		.out_ready            (m_axis_tready),
		.record_type          (record_type),
		.record_class         (m_axis_tuser),
		.payload_len          (payload_len),
		.start_seen           (start_seen),
		.handshake_start_time (handshake_start_time),
		.handshake_end_time   (handshake_end_time),
		.handshake_done       (handshake_done)
	);

	assign m_axis_tdata = {6'd0, handshake_done, handshake_end_time,
		handshake_start_time, start_seen, payload_len, record_type};

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_status.full || q_pop))
		else $error("record queue overflow");

	a_app_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == tlsrf_pkg::CLASS_APPDATA)) |-> handshake_done)
		else $error("application data result without handshake done");

	a_nothing_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && handshake_done) |=> !m_axis_tvalid)
		else $error("result after handshake completion");
`endif

endmodule
